### rtl/qat_pkg.sv
package qat_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 1024;

    localparam int unsigned VIEW_W     = 32;
    localparam int unsigned OP_W       = 32;
    localparam int unsigned ACKS_W     = 32;
    localparam int unsigned REPLICA_W  = 5;
    localparam int unsigned COUNT_W    = 6;
    localparam int unsigned VERDICT_W  = 2;
    localparam int unsigned S_TDATA_W  = 72;
    localparam int unsigned M_TDATA_W  = 8;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_MISMATCH   = 2'd0,
        VERDICT_DROP       = 2'd1,
        VERDICT_QUORUM     = 2'd2,
        VERDICT_REGISTERED = 2'd3
    } verdict_t;

    typedef struct packed {
        logic [VIEW_W-1:0] view;
        logic [OP_W-1:0]   op;
        logic [ACKS_W-1:0] acks;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;
        logic in_load;
        logic mod_start;
        logic ram_read;
        logic eval;
        logic count;
        logic emit;
    } qat_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic mod_done;
        logic out_free;
    } qat_status_t;

    // Bit count of a nibble.
    function automatic logic [2:0] nibble_ones(input logic [3:0] v);
        logic [2:0] n;
        case (v)
            4'h0: n = 3'd0;
            4'h1, 4'h2, 4'h4, 4'h8: n = 3'd1;
            4'h3, 4'h5, 4'h6, 4'h9, 4'hA, 4'hC: n = 3'd2;
            4'h7, 4'hB, 4'hD, 4'hE: n = 3'd3;
            4'hF: n = 3'd4;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    // Bit count of the acknowledgement set, eight nibble counts summed.
    function automatic logic [COUNT_W-1:0] count_ones(input logic [ACKS_W-1:0] v);
        logic [COUNT_W-1:0] sum;
        sum = '0;
        for (int i = 0; i < ACKS_W / 4; i++) begin
            sum = sum + COUNT_W'(nibble_ones(v[4*i +: 4]));
        end
        return sum;
    endfunction

endpackage

### rtl/quorum_ack_tracker.sv
// Channel   Dir  Beat content (lowest bits first)
// s_*       in   tuser: kind; tdata: view_number, op_number, replica_index, zero fill
// m_*       out  tuser: verdict; tdata: ack_count, zero fill
// cfg_*     in   acks_needed write, no read-back
//
// One item is handled at a time. With a power-of-two table an item goes
// from acceptance to the next acceptance through the index mask, the table
// read, the compare and write-back, the bit count and the result load. With
// any other table size the index unit needs a reciprocal multiply and a
// multiply-subtract, each registered, in place of the mask. After reset the
// table is swept to zero, one entry per cycle, and s_tready stays low until
// the sweep ends. A held-off result beat keeps the next item from finishing
// but not from being accepted.
module quorum_ack_tracker #(
    parameter int unsigned TABLE_ENTRIES = qat_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [31:0] view_number, [63:32] op_number, [68:64] replica_index, [71:69] zero
    input  logic [qat_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] kind: 0 registers a prepare, 1 is an acknowledgement
    input  logic                           s_tuser,

    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [5:0] ack_count, [7:6] zero
    output logic [qat_pkg::M_TDATA_W-1:0]  m_tdata,
    // [1:0] verdict
    output logic [qat_pkg::VERDICT_W-1:0]  m_tuser,

    input  logic                           cfg_wr_en,
    input  logic [qat_pkg::COUNT_W-1:0]    cfg_wr_data
);

    // The controller steps each item through the sequence above; the
    // datapath owns the table, the index unit and the result register.
    qat_pkg::qat_cmd_t    cmd;
    qat_pkg::qat_status_t status;

    qat_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    qat_dp #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .cmd        (cmd),
        .status     (status)
    );

endmodule

### rtl/qat_ram.sv
module qat_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/qat_mod.sv
// Table index from an operation number: a mask for power-of-two sizes,
// otherwise the quotient from a rounded-up reciprocal, which is registered,
// and the remainder from a multiply-subtract in the cycle after.
module qat_mod #(
    parameter int unsigned TABLE_ENTRIES = qat_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [qat_pkg::OP_W-1:0]         op,
    output logic [$clog2(TABLE_ENTRIES)-1:0] idx,
    output logic                             done
);

    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

    if ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0) begin : g_mask
        logic [IDX_W-1:0] idx_reg;
        logic             done_reg;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                done_reg <= 1'b0;
            end else begin
                done_reg <= start;
            end
            if (start) begin
                idx_reg <= op[IDX_W-1:0];
            end
        end

        assign idx  = idx_reg;
        assign done = done_reg;
    end else begin : g_recip
        // With SHIFT = 32 + ceil(log2(N)) and RECIP = ceil(2^SHIFT / N), the
        // product shifted down by SHIFT is the exact quotient for every
        // 32-bit operand. RECIP fits in 33 bits for any N that is not a
        // power of two.
        localparam int unsigned PROD_W = 2 * qat_pkg::OP_W + 1;
        localparam int unsigned SHIFT  = qat_pkg::OP_W + IDX_W;
        localparam logic [63:0] RECIP_WIDE =
            ((64'd1 << SHIFT) + 64'(TABLE_ENTRIES) - 64'd1) / 64'(TABLE_ENTRIES);
        localparam logic [qat_pkg::OP_W:0]   RECIP   = (qat_pkg::OP_W + 1)'(RECIP_WIDE);
        localparam logic [qat_pkg::OP_W-1:0] MODULUS = qat_pkg::OP_W'(TABLE_ENTRIES);

        logic [PROD_W-1:0]         prod;
        logic [qat_pkg::OP_W-1:0]  quot;
        logic [qat_pkg::OP_W-1:0]  rem;
        logic [qat_pkg::OP_W-1:0]  op_reg;
        logic [qat_pkg::OP_W-1:0]  quot_reg;
        logic [IDX_W-1:0]          idx_reg;
        logic                      step_reg;
        logic                      done_reg;

        always_comb begin
            prod = PROD_W'(op) * PROD_W'(RECIP);
            quot = qat_pkg::OP_W'(prod >> SHIFT);
            rem  = op_reg - quot_reg * MODULUS;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                step_reg <= 1'b0;
                done_reg <= 1'b0;
            end else begin
                step_reg <= start;
                done_reg <= step_reg;
            end
            if (start) begin
                op_reg   <= op;
                quot_reg <= quot;
            end
            if (step_reg) begin
                idx_reg <= rem[IDX_W-1:0];
            end
        end

        assign idx  = idx_reg;
        assign done = done_reg;
    end

endmodule

### rtl/qat_ctrl.sv
module qat_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  qat_pkg::qat_status_t status,
    output qat_pkg::qat_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_READ,
        ST_EVAL,
        ST_COUNT,
        ST_EMIT
    } state_t;

    state_t state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            case (state_reg)
                ST_CLEAR: begin
                    if (status.clear_last) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_MOD;
                    end
                end
                ST_MOD: begin
                    if (status.mod_done) begin
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:  state_reg <= ST_EVAL;
                ST_EVAL:  state_reg <= ST_COUNT;
                ST_COUNT: state_reg <= ST_EMIT;
                ST_EMIT: begin
                    if (status.out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_CLEAR;
            endcase
        end
    end

    assign s_tready       = (state_reg == ST_IDLE);
    assign cmd.clear_step = (state_reg == ST_CLEAR);
    assign cmd.in_load    = s_tready && s_tvalid;
    assign cmd.mod_start  = s_tready && s_tvalid;
    assign cmd.ram_read   = (state_reg == ST_READ);
    assign cmd.eval       = (state_reg == ST_EVAL);
    assign cmd.count      = (state_reg == ST_COUNT);
    assign cmd.emit       = (state_reg == ST_EMIT) && status.out_free;

endmodule

### rtl/qat_dp.sv
module qat_dp #(
    parameter int unsigned TABLE_ENTRIES = qat_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [qat_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [qat_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [qat_pkg::VERDICT_W-1:0]     m_tuser,
    input  logic                              cfg_wr_en,
    input  logic [qat_pkg::COUNT_W-1:0]       cfg_wr_data,
    input  qat_pkg::qat_cmd_t                 cmd,
    output qat_pkg::qat_status_t              status
);

    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    logic                              kind_reg;
    logic [qat_pkg::VIEW_W-1:0]        view_reg;
    logic [qat_pkg::OP_W-1:0]          op_reg;
    logic [qat_pkg::REPLICA_W-1:0]     replica_reg;
    logic [qat_pkg::COUNT_W-1:0]       acks_needed_reg;
    logic [IDX_W-1:0]                  clr_addr_reg;
    logic [IDX_W-1:0]                  idx;
    logic                              mod_done;
    logic [qat_pkg::ENTRY_W-1:0]       rdata;
    qat_pkg::entry_t                   old_entry;
    qat_pkg::entry_t                   new_entry;
    logic                              match;
    logic                              match_reg;
    logic [qat_pkg::ACKS_W-1:0]        acks_reg;
    logic [qat_pkg::COUNT_W-1:0]       count_reg;
    qat_pkg::verdict_t                 verdict;
    logic                              ram_we;
    logic [IDX_W-1:0]                  ram_waddr;
    logic [qat_pkg::ENTRY_W-1:0]       ram_wdata;
    logic                              m_tvalid_reg;
    logic [qat_pkg::COUNT_W-1:0]       m_count_reg;
    qat_pkg::verdict_t                 m_verdict_reg;

    qat_mod #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_mod (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (cmd.mod_start),
        .op     (s_tdata[2*qat_pkg::OP_W-1:qat_pkg::OP_W]),
        .idx    (idx),
        .done   (mod_done)
    );

    qat_ram #(
        .WIDTH(qat_pkg::ENTRY_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_table (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (cmd.ram_read),
        .raddr(idx),
        .rdata(rdata)
    );

    always_comb begin
        old_entry = qat_pkg::entry_t'(rdata);
        match     = (old_entry.view == view_reg) && (old_entry.op == op_reg);
        new_entry = old_entry;
        if (!kind_reg && !match) begin
            new_entry.view = view_reg;
            new_entry.op   = op_reg;
            new_entry.acks = '0;
        end else if (kind_reg && match) begin
            new_entry.acks = old_entry.acks
                           | (qat_pkg::ACKS_W'(1) << replica_reg);
        end
    end

    // The clearing sweep and the per-item update share the write port.
    always_comb begin
        if (cmd.clear_step) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = cmd.eval;
            ram_waddr = idx;
            ram_wdata = new_entry;
        end
    end

    always_comb begin
        if (!kind_reg) begin
            verdict = qat_pkg::VERDICT_REGISTERED;
        end else if (!match_reg) begin
            verdict = qat_pkg::VERDICT_MISMATCH;
        end else if (count_reg == acks_needed_reg) begin
            verdict = qat_pkg::VERDICT_QUORUM;
        end else begin
            verdict = qat_pkg::VERDICT_DROP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acks_needed_reg <= qat_pkg::COUNT_W'(1);
            clr_addr_reg    <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                acks_needed_reg <= cfg_wr_data;
            end
            if (cmd.clear_step) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        if (cmd.in_load) begin
            kind_reg    <= s_tuser;
            view_reg    <= s_tdata[qat_pkg::VIEW_W-1:0];
            op_reg      <= s_tdata[2*qat_pkg::OP_W-1:qat_pkg::OP_W];
            replica_reg <= s_tdata[2*qat_pkg::OP_W +: qat_pkg::REPLICA_W];
        end
        if (cmd.eval) begin
            match_reg <= match;
            acks_reg  <= new_entry.acks;
        end
        if (cmd.count) begin
            count_reg <= qat_pkg::count_ones(acks_reg);
        end
        if (cmd.emit) begin
            m_verdict_reg <= verdict;
            m_count_reg   <= count_reg;
        end
    end

    assign status.clear_last = (clr_addr_reg == LAST_IDX);
    assign status.mod_done   = mod_done;
    assign status.out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(qat_pkg::M_TDATA_W - qat_pkg::COUNT_W)'(0), m_count_reg};
    assign m_tuser  = m_verdict_reg;

endmodule

### bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qat_pkg::*;

    // The bench runs the block at its default table size and mirrors that size.
    localparam int unsigned TBL_N = TABLE_ENTRIES_DEF;

    // Meaning of s_tuser.
    localparam logic KIND_PREPARE = 1'b0;
    localparam logic KIND_ACK     = 1'b1;

    // The receiver's long hold-off, in cycles.
    localparam int HOLD_CYCLES = 300;
    // Cycles allowed for an item still inside the block once the last result
    // has arrived.
    localparam int SETTLE_CYCLES = 12;
    // Cycles with no beat on either channel before the run is declared hung.
    // The clearing sweep after reset and the hold-off above are the longest
    // quiet stretches of a correct run.
    localparam int STALL_LIMIT = 5000;
    // Random beats per threshold setting.
    localparam int PHASE_BEATS = 148;

    typedef struct packed {
        verdict_t            verdict;
        logic [COUNT_W-1:0]  count;
    } tracked_result_t;

    typedef struct packed {
        logic [VIEW_W-1:0] view;
        logic [OP_W-1:0]   op;
    } op_key_t;

    logic                    aclk        = 1'b0;
    logic                    aresetn     = 1'b0;
    logic                    s_tvalid    = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata     = '0;
    logic                    s_tuser     = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic [VERDICT_W-1:0]    m_tuser;
    logic                    cfg_wr_en   = 1'b0;
    logic [COUNT_W-1:0]      cfg_wr_data = '0;

    quorum_ack_tracker #(
        .TABLE_ENTRIES(TBL_N)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the block: the slot table, the threshold and the results
    // that are owed, oldest first.
    // ------------------------------------------------------------------
    logic [VIEW_W-1:0]  tbl_view [TBL_N] = '{default: '0};
    logic [OP_W-1:0]    tbl_op   [TBL_N] = '{default: '0};
    logic [ACKS_W-1:0]  tbl_acks [TBL_N] = '{default: '0};
    logic [COUNT_W-1:0] ack_threshold = 6'd1;
    tracked_result_t    pending_results [$];

    // Keys of recent prepares, so that later rounds can revisit or alias them.
    op_key_t recent_keys [$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_trigger = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int mismatches = 0;
    int beats_sent = 0;
    int verdict_seen [4] = '{default: 0};
    int stall_cycles = 0;

    // Applies one accepted beat to the shadow table and queues its result.
    // A prepare claims the slot unless view and operation already match; a
    // matching acknowledgement sets its replica's bit and is compared with
    // the threshold; any other acknowledgement leaves the slot alone.
    function automatic void track_beat(input logic kind, input logic [VIEW_W-1:0] view,
                                       input logic [OP_W-1:0] op,
                                       input logic [REPLICA_W-1:0] replica);
        int unsigned     slot;
        logic            hit;
        tracked_result_t res;
        slot = op % TBL_N;
        hit  = (tbl_view[slot] == view) && (tbl_op[slot] == op);
        if (kind == KIND_PREPARE) begin
            if (!hit) begin
                tbl_view[slot] = view;
                tbl_op[slot]   = op;
                tbl_acks[slot] = '0;
            end
            res.verdict = VERDICT_REGISTERED;
            res.count   = COUNT_W'($countones(tbl_acks[slot]));
        end else if (!hit) begin
            res.verdict = VERDICT_MISMATCH;
            res.count   = COUNT_W'($countones(tbl_acks[slot]));
        end else begin
            // A bit that is already set leaves the count where it was, but the
            // threshold compare still happens.
            tbl_acks[slot][replica] = 1'b1;
            res.count   = COUNT_W'($countones(tbl_acks[slot]));
            res.verdict = (res.count == ack_threshold) ? VERDICT_QUORUM : VERDICT_DROP;
        end
        pending_results.push_back(res);
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, plus a long hold-off on request. The
    // request is a counter bumped by the stimulus, so it is seen at the next edge
    // after it is made and never races the stimulus process.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_trigger != hold_seen) begin
            hold_seen <= hold_trigger;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result check: every result beat is matched against the oldest owed
    // result. Verdict and the whole of tdata (count plus zero fill) are
    // compared separately.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        tracked_result_t owed;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with nothing owed: verdict %0d, tdata 0x%02h",
                         $time, m_tuser, m_tdata);
                mismatches++;
            end else begin
                owed = pending_results.pop_front();
                verdict_seen[owed.verdict]++;
                if (m_tuser !== owed.verdict) begin
                    $display("%0t: verdict expected %0d (%s), actual %0d",
                             $time, owed.verdict, owed.verdict.name(), m_tuser);
                    mismatches++;
                end
                if (m_tdata !== {{(M_TDATA_W-COUNT_W){1'b0}}, owed.count}) begin
                    $display("%0t: tdata expected 0x%02h (ack_count %0d), actual 0x%02h",
                             $time, {{(M_TDATA_W-COUNT_W){1'b0}}, owed.count},
                             owed.count, m_tdata);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: a run that goes quiet for too long has hung.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat for %0d cycles, %0d results still owed",
                         $time, STALL_LIMIT, pending_results.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Offers one beat, with random idle cycles ahead of it, and records it in
    // the shadow once it is accepted. tvalid stays high afterwards so that a
    // following beat goes out back to back.
    task automatic send_beat(input logic kind, input logic [VIEW_W-1:0] view,
                             input logic [OP_W-1:0] op,
                             input logic [REPLICA_W-1:0] replica);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(S_TDATA_W-VIEW_W-OP_W-REPLICA_W){1'b0}}, replica, op, view};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        track_beat(kind, view, op, replica);
        beats_sent++;
    endtask

    // Waits until every owed result has arrived and the block has settled.
    task automatic wait_for_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes the threshold register while nothing is in flight.
    task automatic set_quorum(input logic [COUNT_W-1:0] value);
        wait_for_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        ack_threshold = value;
    endtask

    // One well-formed round: a prepare, then a run of acknowledgements from
    // replicas in shuffled order, with the odd duplicate and the odd stray
    // acknowledgement that lands on the same slot but does not match it.
    task automatic run_quorum_round(output int n_sent);
        logic [VIEW_W-1:0]    view;
        logic [OP_W-1:0]      op;
        logic [REPLICA_W-1:0] perm [32];
        logic [REPLICA_W-1:0] tmp;
        logic [REPLICA_W-1:0] replica;
        op_key_t              key;
        int                   sel;
        int                   swap_at;
        int                   next_fresh;
        int                   n_acks;
        int                   hi;
        n_sent = 0;
        sel = $urandom_range(0, 99);
        if (recent_keys.size() != 0 && sel < 25) begin
            // Revisit an earlier operation: its slot may still match.
            key  = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
            view = key.view;
            op   = key.op;
        end else if (recent_keys.size() != 0 && sel < 45) begin
            // Another operation that maps onto the slot of an earlier one.
            key  = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
            view = $urandom();
            op   = key.op + OP_W'(TBL_N * $urandom_range(1, 4096));
        end else begin
            view = $urandom();
            op   = $urandom();
        end
        key.view = view;
        key.op   = op;
        recent_keys.push_back(key);
        if (recent_keys.size() > 16) begin
            void'(recent_keys.pop_front());
        end
        send_beat(KIND_PREPARE, view, op, REPLICA_W'($urandom_range(0, 31)));
        n_sent++;

        for (int i = 0; i < 32; i++) begin
            perm[i] = REPLICA_W'(i);
        end
        for (int i = 0; i < 31; i++) begin
            swap_at       = $urandom_range(i, 31);
            tmp           = perm[i];
            perm[i]       = perm[swap_at];
            perm[swap_at] = tmp;
        end

        // Half the rounds stop near the threshold, so quorums are frequent.
        hi = int'(ack_threshold) + 2;
        if (hi > 34) begin
            hi = 34;
        end
        n_acks = $urandom_range(0, 1) ? $urandom_range(1, hi) : $urandom_range(1, 34);
        next_fresh = 0;
        for (int k = 0; k < n_acks; k++) begin
            if ($urandom_range(0, 99) < 8) begin
                if ($urandom_range(0, 1)) begin
                    send_beat(KIND_ACK, view ^ (32'd1 << $urandom_range(0, 31)), op,
                              REPLICA_W'($urandom_range(0, 31)));
                end else begin
                    send_beat(KIND_ACK, view, op + OP_W'(TBL_N * $urandom_range(1, 4096)),
                              REPLICA_W'($urandom_range(0, 31)));
                end
            end else begin
                if (next_fresh < 32 && $urandom_range(0, 99) >= 12) begin
                    replica = perm[next_fresh];
                    next_fresh++;
                end else begin
                    replica = perm[$urandom_range(0, (next_fresh == 0) ? 0 : next_fresh - 1)];
                end
                send_beat(KIND_ACK, view, op, replica);
            end
            n_sent++;
        end
    endtask

    // A single unstructured beat: mostly random, sometimes an acknowledgement
    // aimed at a recent operation from any replica.
    task automatic send_noise_beat();
        op_key_t key;
        if (recent_keys.size() != 0 && $urandom_range(0, 99) < 30) begin
            key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
            send_beat(KIND_ACK, key.view, key.op, REPLICA_W'($urandom_range(0, 31)));
        end else begin
            send_beat(1'($urandom_range(0, 1)), $urandom(), $urandom(),
                      REPLICA_W'($urandom_range(0, 31)));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // After reset every slot holds view 0, operation 0 with no bits set, so
    // an acknowledgement for that key is counted. Threshold is the reset 1.
    task automatic test_cleared_slot();
        send_beat(KIND_ACK, 32'd0, 32'd0, 5'd7);
        // Same replica again: the count stays at one and still meets the threshold.
        send_beat(KIND_ACK, 32'd0, 32'd0, 5'd7);
        send_beat(KIND_ACK, 32'd0, 32'(TBL_N), 5'd1);
        send_beat(KIND_ACK, 32'd9, 32'd3, 5'd0);
    endtask

    // A prepare claims a slot; a repeated prepare for the same key keeps the
    // count, while one for a new view resets it.
    task automatic test_registration();
        send_beat(KIND_PREPARE, 32'h1234_5678, 32'h40, 5'd0);
        send_beat(KIND_ACK,     32'h1234_5678, 32'h40, 5'd3);
        send_beat(KIND_PREPARE, 32'h1234_5678, 32'h40, 5'd31);
        send_beat(KIND_PREPARE, 32'h1234_5679, 32'h40, 5'd0);
        send_beat(KIND_ACK,     32'h1234_5678, 32'h40, 5'd3);
    endtask

    // Two operations that share a slot: the later prepare evicts the earlier.
    task automatic test_table_alias();
        send_beat(KIND_PREPARE, 32'd7, 32'd5, 5'd0);
        send_beat(KIND_PREPARE, 32'd7, 32'd5 + 32'(TBL_N), 5'd0);
        send_beat(KIND_ACK,     32'd7, 32'd5, 5'd2);
        send_beat(KIND_ACK,     32'd7, 32'd5 + 32'(TBL_N), 5'd0);
    endtask

    // All-ones view and operation, highest and lowest replica.
    task automatic test_field_extremes();
        send_beat(KIND_PREPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
        send_beat(KIND_ACK,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
        send_beat(KIND_ACK,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0);
    endtask

    // A threshold of two, then thresholds of zero and 63 that no count can meet.
    task automatic test_thresholds();
        set_quorum(6'd2);
        send_beat(KIND_PREPARE, 32'hA5A5_A5A5, 32'h100, 5'd0);
        send_beat(KIND_ACK,     32'hA5A5_A5A5, 32'h100, 5'd1);
        send_beat(KIND_ACK,     32'hA5A5_A5A5, 32'h100, 5'd2);
        send_beat(KIND_ACK,     32'hA5A5_A5A5, 32'h100, 5'd4);
        set_quorum(6'd0);
        send_beat(KIND_ACK,     32'hA5A5_A5A5, 32'h100, 5'd5);
        set_quorum(6'd63);
        send_beat(KIND_ACK,     32'hA5A5_A5A5, 32'h100, 5'd6);
        send_beat(KIND_PREPARE, 32'hA5A5_A5A5, 32'h100, 5'd0);
    endtask

    // The receiver holds off for a long stretch while rounds keep coming, so
    // the block fills and drops s_tready until the hold ends.
    task automatic test_backpressure();
        int total;
        int n;
        set_quorum(6'd3);
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        hold_trigger <= hold_trigger + 1;
        total = 0;
        while (total < 30) begin
            run_quorum_round(n);
            total += n;
        end
    endtask

    // Random rounds under nine thresholds, the extremes 1 and 32 among them,
    // and three idle patterns: sender idles 27% and receiver 45%, then the
    // other way round, then neither.
    task automatic test_random_phases();
        int quorum_plan [9] = '{1, 32, -1, 2, 32, -1, 1, -1, 32};
        int tx_plan [3] = '{27, 45, 0};
        int rx_plan [3] = '{45, 27, 0};
        int sent;
        int n;
        for (int phase = 0; phase < 9; phase++) begin
            if (quorum_plan[phase] < 0) begin
                set_quorum(COUNT_W'($urandom_range(1, 32)));
            end else begin
                set_quorum(COUNT_W'(quorum_plan[phase]));
            end
            tx_idle_pct = tx_plan[phase / 3];
            rx_idle_pct <= rx_plan[phase / 3];
            sent = 0;
            while (sent < PHASE_BEATS) begin
                if ($urandom_range(0, 99) < 75) begin
                    run_quorum_round(n);
                    sent += n;
                end else begin
                    send_noise_beat();
                    sent++;
                end
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // The block sweeps its table after reset; the first beat simply waits
        // for s_tready.
        test_cleared_slot();
        test_registration();
        test_table_alias();
        test_field_extremes();
        test_thresholds();
        test_backpressure();
        test_random_phases();

        wait_for_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Run covered %0d input beats: %0d quorum, %0d drop, %0d mismatch, %0d registered.",
                 beats_sent, verdict_seen[VERDICT_QUORUM], verdict_seen[VERDICT_DROP],
                 verdict_seen[VERDICT_MISMATCH], verdict_seen[VERDICT_REGISTERED]);
        $display("Thresholds 0 to 63 incl. both extremes, three idle patterns and one long hold-off.");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
